@@ sv/hdtc_pkg.sv @@
// Package for the hex/decimal text converter.
// Holds the channel item types, the character codes and the controller/datapath
// command and status structs. Depends on nothing.
package hdtc_pkg;

  typedef struct packed {
    logic [7:0] in_char;
    logic       token_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_item_t;

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_F = 8'h46;
  localparam logic [7:0] CHAR_X     = 8'h78;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_NL    = 8'h0A;

  // Character sources for the output register
  localparam logic [1:0] EMIT_ZERO  = 2'd0;
  localparam logic [1:0] EMIT_X     = 2'd1;
  localparam logic [1:0] EMIT_DIGIT = 2'd2;
  localparam logic [1:0] EMIT_NL    = 2'd3;

  typedef struct packed {
    logic       step;        // parse the accepted character
    logic       dab_start;   // clear BCD, load bit counter
    logic       dab_step;    // one shift-add-3 iteration
    logic       dec_load;    // move BCD result into digit shifter
    logic       hex_load;    // move value into digit shifter
    logic       digit_next;  // drop the top digit
    logic       emit;        // write output register
    logic [1:0] emit_sel;
    logic       clear;       // end of token
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic hex_token;
    logic neg_nonzero;
    logic dab_last;
    logic digit_skip;
    logic digit_last;
  } dp_status_t;

endpackage

@@ sv/hdtc_datapath.sv @@
// Datapath of the hex/decimal text converter: token parser, binary-to-BCD
// shifter, digit shifter and output register. Depends on hdtc_pkg.
module hdtc_datapath import hdtc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_item,
  input  logic       out_stall,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DIG_N      = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DEC_W      = DEC_DIGITS * 4;
  localparam int DIG_W      = DIG_N * 4;
  localparam int DEC_SHIFT  = (DIG_N - DEC_DIGITS) * 4;
  localparam int HEX_SHIFT  = (DIG_N - HEX_DIGITS) * 4;
  localparam int CNT_W      = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] value_acc, value_next;
  logic [1:0]             char_pos;
  logic                   hex_token, neg_sign, dec_stopped;
  logic                   hex_next, neg_next, stopped_next;
  logic [DEC_W-1:0]       bcd, bcd_adj;
  logic [DIG_W-1:0]       dig;
  logic [CNT_W-1:0]       cnt;
  logic                   started;

  logic [7:0]             c;
  logic [3:0]             hex_val;
  logic [3:0]             dec_val;
  logic                   is_dec;
  logic [3:0]             top;
  logic [7:0]             top_char;
  logic [7:0]             emit_char;

  assign c       = in_item.in_char;
  assign is_dec  = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign dec_val = 4'(c - CHAR_ZERO);
  assign top     = dig[DIG_W-1 -: 4];

  always_comb begin
    if (is_dec) begin
      hex_val = dec_val;
    end else if ((c >= CHAR_UPPER_A) && (c <= CHAR_UPPER_F)) begin
      hex_val = 4'(c - CHAR_UPPER_A + 8'd10);
    end else begin
      hex_val = 4'd0;
    end
  end

  // Parse one character
  always_comb begin
    value_next   = value_acc;
    hex_next     = hex_token;
    neg_next     = neg_sign;
    stopped_next = dec_stopped;
    if ((char_pos == 2'd1) && (c == CHAR_X)) begin
      hex_next   = 1'b1;
      value_next = '0;
      neg_next   = 1'b0;
    end else if (hex_token) begin
      if (c == CHAR_X) begin
        value_next = '0;
      end else begin
        value_next = (value_acc << 4) | VALUE_WIDTH'(hex_val);
      end
    end else if (!dec_stopped) begin
      if ((char_pos == 2'd0) && ((c == CHAR_PLUS) || (c == CHAR_MINUS))) begin
        neg_next = (c == CHAR_MINUS);
      end else if (is_dec) begin
        value_next = (value_acc << 3) + (value_acc << 1) + VALUE_WIDTH'(dec_val);
      end else begin
        stopped_next = 1'b1;
      end
    end
  end

  // Add 3 to every BCD digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*4 +: 4] = (bcd[i*4 +: 4] >= 4'd5) ? bcd[i*4 +: 4] + 4'd3 : bcd[i*4 +: 4];
    end
  end

  always_comb begin
    top_char = (top < 4'd10) ? CHAR_ZERO + 8'(top) : CHAR_UPPER_A + 8'(top - 4'd10);
    case (cmd.emit_sel)
      EMIT_ZERO:  emit_char = CHAR_ZERO;
      EMIT_X:     emit_char = CHAR_X;
      EMIT_DIGIT: emit_char = top_char;
      EMIT_NL:    emit_char = CHAR_NL;
      default:    emit_char = CHAR_NL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      value_acc   <= '0;
      char_pos    <= 2'd0;
      hex_token   <= 1'b0;
      neg_sign    <= 1'b0;
      dec_stopped <= 1'b0;
      cnt         <= '0;
      started     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.step) begin
        value_acc   <= value_next;
        hex_token   <= hex_next;
        neg_sign    <= neg_next;
        dec_stopped <= stopped_next;
        if (char_pos != 2'd2) begin
          char_pos <= char_pos + 2'd1;
        end
      end
      if (cmd.dab_start) begin
        cnt <= CNT_W'(VALUE_WIDTH);
      end
      if (cmd.dab_step) begin
        value_acc <= value_acc << 1;
        cnt       <= cnt - 1'b1;
      end
      if (cmd.dec_load) begin
        cnt     <= CNT_W'(DEC_DIGITS);
        started <= 1'b0;
      end
      if (cmd.hex_load) begin
        cnt     <= CNT_W'(HEX_DIGITS);
        started <= 1'b0;
      end
      if (cmd.digit_next) begin
        cnt <= cnt - 1'b1;
        if (cmd.emit) begin
          started <= 1'b1;
        end
      end
      if (cmd.clear) begin
        value_acc   <= '0;
        char_pos    <= 2'd0;
        hex_token   <= 1'b0;
        neg_sign    <= 1'b0;
        dec_stopped <= 1'b0;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.dab_start) begin
      bcd <= '0;
    end else if (cmd.dab_step) begin
      bcd <= {bcd_adj[DEC_W-2:0], value_acc[VALUE_WIDTH-1]};
    end
    if (cmd.dec_load) begin
      dig <= DIG_W'(bcd) << DEC_SHIFT;
    end else if (cmd.hex_load) begin
      dig <= DIG_W'(value_acc) << HEX_SHIFT;
    end else if (cmd.digit_next) begin
      dig <= dig << 4;
    end
    if (cmd.emit) begin
      out_item.out_char    <= emit_char;
      out_item.last_of_run <= (cmd.emit_sel == EMIT_NL);
    end
  end

  assign status.out_free    = !out_valid || !out_stall;
  assign status.hex_token   = hex_token;
  assign status.neg_nonzero = neg_sign && (value_acc != '0);
  assign status.dab_last    = (cnt == CNT_W'(1));
  assign status.digit_last  = (cnt == CNT_W'(1));
  assign status.digit_skip  = (top == 4'd0) && !started && (cnt != CNT_W'(1));

endmodule

@@ sv/hdtc_controller.sv @@
// Controller of the hex/decimal text converter: sequences parsing,
// conversion and character output. Depends on hdtc_pkg.
module hdtc_controller import hdtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       token_end,
  input  dp_status_t status,
  output logic       in_stall,
  output dp_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_END    = 4'd1;
  localparam logic [3:0] S_DABBLE = 4'd2;
  localparam logic [3:0] S_DLOAD  = 4'd3;
  localparam logic [3:0] S_PFX0   = 4'd4;
  localparam logic [3:0] S_PFXX   = 4'd5;
  localparam logic [3:0] S_DIGITS = 4'd6;
  localparam logic [3:0] S_NL     = 4'd7;
  localparam logic [3:0] S_HALT   = 4'd8;

  logic [3:0] state, state_next;

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.step = 1'b1;
          if (token_end) begin
            state_next = S_END;
          end
        end
      end
      S_END: begin
        if (status.hex_token) begin
          cmd.dab_start = 1'b1;
          state_next    = S_DABBLE;
        end else if (status.neg_nonzero) begin
          state_next = S_HALT;
        end else begin
          cmd.hex_load = 1'b1;
          state_next   = S_PFX0;
        end
      end
      S_DABBLE: begin
        cmd.dab_step = 1'b1;
        if (status.dab_last) begin
          state_next = S_DLOAD;
        end
      end
      S_DLOAD: begin
        cmd.dec_load = 1'b1;
        state_next   = S_DIGITS;
      end
      S_PFX0: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_ZERO;
          state_next   = S_PFXX;
        end
      end
      S_PFXX: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_X;
          state_next   = S_DIGITS;
        end
      end
      S_DIGITS: begin
        if (status.digit_skip) begin
          cmd.digit_next = 1'b1;
        end else if (status.out_free) begin
          cmd.emit       = 1'b1;
          cmd.emit_sel   = EMIT_DIGIT;
          cmd.digit_next = 1'b1;
          if (status.digit_last) begin
            state_next = S_NL;
          end
        end
      end
      S_NL: begin
        if (status.out_free) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_NL;
          cmd.clear    = 1'b1;
          state_next   = S_IDLE;
        end
      end
      S_HALT: begin
        // drop everything until reset
        in_stall = 1'b0;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ sv/hex_decimal_text_converter.sv @@
// Top level of the hex/decimal text converter.
// Joins hdtc_controller and hdtc_datapath; depends on hdtc_pkg.
//
//  Channel   | Handshake               | Payload
//  ----------+-------------------------+---------------------------------
//  input     | in_valid / in_stall     | in_item  (in_char, token_end)
//  output    | out_valid / out_stall   | out_item (out_char, last_of_run)
//
// A character that does not end a token is parsed as it is accepted.
// A hex token's end runs the shift-add-3 conversion over all VALUE_WIDTH
// bits of the value and then writes out the decimal digits.
// A decimal token's end writes a 0x prefix and then the hex digits;
// both digit walks run through the single digit shifter.
// Reset is synchronous and clears the token state and any halt.
// Output stalls hold each character write; input is stalled while a number is written out.
module hex_decimal_text_converter import hdtc_pkg::*; #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  // Commands from the controller, status back from the datapath
  dp_cmd_t    cmd;
  dp_status_t status;

  hdtc_controller u_controller (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .token_end (in_item.token_end),
    .status    (status),
    .in_stall  (in_stall),
    .cmd       (cmd)
  );

  hdtc_datapath #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule
